>>> src/orm_pkg.sv
// Shared types and constants of the operations rate meter.
`default_nettype none

package orm_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CNT_W       = 64;
  localparam int unsigned RATE_W      = 48;
  localparam int unsigned UPT_W       = 39;
  // Numerator of the shared divider: an operation delta times 1000 needs ten more bits.
  localparam int unsigned NUM_W       = CNT_W + 10;
  localparam int unsigned DEN_W       = TIME_W;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_OP    = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // One tick or query waiting for the back end, with the counter value at its arrival.
  typedef struct packed {
    logic              is_query;
    logic [TIME_W-1:0] now_ms;
    logic [CNT_W-1:0]  count;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/orm_front.sv
// Front end: accepts items, counts operation events and queues ticks and queries.
`default_nettype none

module orm_front import orm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,  // [47:0] now_ms
  input  wire logic [CMD_W-1:0]      s_axis_tuser_i,  // [1:0] command
  output q_item_t                    push_item_o,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i
);

  logic [CNT_W-1:0] op_count_q, op_count_d;
  logic             is_op, is_tick, is_query, needs_queue;

  always_comb begin
    is_op    = (s_axis_tuser_i == CMD_OP);
    is_tick  = (s_axis_tuser_i == CMD_TICK);
    is_query = (s_axis_tuser_i == CMD_QUERY);
    needs_queue = is_tick || is_query;
  end

  // Operation events and unused codes never wait for the queue.
  assign s_axis_tready_o = !needs_queue || push_ready_i;
  assign push_valid_o    = s_axis_tvalid_i && needs_queue;

  always_comb begin
    push_item_o.is_query = is_query;
    push_item_o.now_ms   = s_axis_tdata_i[TIME_W-1:0];
    push_item_o.count    = op_count_q;
  end

  always_comb begin
    op_count_d = op_count_q;
    if (s_axis_tvalid_i && is_op) begin
      op_count_d = op_count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_count_q <= '0;
    end else begin
      op_count_q <= op_count_d;
    end
  end

endmodule

`default_nettype wire

>>> src/orm_queue.sv
// Short queue that decouples the front end from the back end.
`default_nettype none

module orm_queue import orm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_item_t push_item_i,
  input  wire logic    push_valid_i,
  output logic         push_ready_o,
  output q_item_t      pop_item_o,
  output logic         pop_valid_o,
  input  wire logic    pop_ready_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/orm_div.sv
// Restoring divider, one quotient bit per cycle, shared by ticks and queries.
`default_nettype none

module orm_div import orm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    partial, diff;
  logic              fits;

  // The numerator shifts out at the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    partial = {rem_q, quo_q[NUM_W-1]};
    diff    = partial - {1'b0, den_q};
    fits    = (partial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

>>> src/orm_back.sv
// Back end: works out tick rates, keeps the sample store and answers info queries.
`default_nettype none

module orm_back import orm_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [TIME_W-1:0]      cfg_data_i,
  input  wire q_item_t                pop_item_i,
  input  wire logic                   pop_valid_i,
  output logic                        pop_ready_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned IDX_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int unsigned SUM_W  = RATE_W + $clog2(SAMPLE_COUNT);
  localparam int unsigned USED_W = $clog2(SAMPLE_COUNT + 1);
  localparam int unsigned UPT_STEP_BITS = 8;
  localparam int unsigned UPT_STEPS     = TIME_W / UPT_STEP_BITS;
  localparam int unsigned UPT_STEP_W    = $clog2(UPT_STEPS);
  localparam int unsigned MS_W          = $clog2(MS_PER_S);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_DIV,
    ST_TICK_WR,
    ST_Q_UPT,
    ST_Q_AVG,
    ST_Q_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic [TIME_W-1:0]       start_q, start_d;
  logic [TIME_W-1:0]       last_time_q, last_time_d;
  logic [CNT_W-1:0]        last_count_q, last_count_d;
  logic [IDX_W-1:0]        wr_idx_q, wr_idx_d;
  logic [SAMPLE_COUNT-1:0] valid_q, valid_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [USED_W-1:0]       used_q, used_d;
  logic [RATE_W-1:0]       rate_q, rate_d;
  logic [UPT_W-1:0]        upt_q, upt_d;
  logic [RATE_W-1:0]       avg_q, avg_d;
  logic                    out_valid_q, out_valid_d;
  logic [UPT_W-1:0]        out_upt_q, out_upt_d;
  logic [RATE_W-1:0]       out_avg_q, out_avg_d;
  logic [TIME_W-1:0]       upt_num_q, upt_num_d;
  logic [MS_W-1:0]         upt_rem_q, upt_rem_d;
  logic [UPT_STEP_W-1:0]   upt_step_q, upt_step_d;

  logic [RATE_W-1:0] mem_q [SAMPLE_COUNT];
  logic [RATE_W-1:0] rdata_q;
  logic              mem_we;

  logic [TIME_W-1:0] span, elapsed;
  logic [CNT_W-1:0]  delta;
  logic [NUM_W-1:0]  scaled;
  logic [RATE_W-1:0] old_rate, sat_rate;
  logic [MS_W-1:0]          ud_rem;
  logic [MS_W:0]            ud_part;
  logic [UPT_STEP_BITS-1:0] ud_bits;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  orm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - RATE_W - UPT_W){1'b0}}, out_avg_q, out_upt_q};

  always_comb begin
    span    = pop_item_i.now_ms - last_time_q;
    elapsed = pop_item_i.now_ms - start_q;
    delta   = pop_item_i.count - last_count_q;
    // Times 1000 as 1024 - 16 - 8.
    scaled  = (NUM_W'(delta) << 10) - (NUM_W'(delta) << 4) - (NUM_W'(delta) << 3);
    sat_rate = (|div_rsp.quo[NUM_W-1:RATE_W]) ? '1 : div_rsp.quo[RATE_W-1:0];
    // A slot never written since reset holds the sample zero.
    old_rate = valid_q[wr_idx_q] ? rdata_q : '0;
  end

  // Milliseconds to seconds: eight quotient bits per cycle by compare and subtract.
  always_comb begin
    ud_rem  = upt_rem_q;
    ud_part = '0;
    ud_bits = '0;
    for (int b = 0; b < UPT_STEP_BITS; b++) begin
      ud_part = {ud_rem, upt_num_q[TIME_W-1-b]};
      ud_bits[UPT_STEP_BITS-1-b] = (ud_part >= (MS_W+1)'(MS_PER_S));
      ud_rem  = ud_bits[UPT_STEP_BITS-1-b] ? MS_W'(ud_part - (MS_W+1)'(MS_PER_S))
                                            : ud_part[MS_W-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    last_time_d  = last_time_q;
    last_count_d = last_count_q;
    wr_idx_d     = wr_idx_q;
    valid_d      = valid_q;
    sum_d        = sum_q;
    used_d       = used_q;
    rate_d       = rate_q;
    upt_d        = upt_q;
    avg_d        = avg_q;
    out_valid_d  = out_valid_q;
    out_upt_d    = out_upt_q;
    out_avg_d    = out_avg_q;
    upt_num_d    = upt_num_q;
    upt_rem_d    = upt_rem_q;
    upt_step_d   = upt_step_q;
    pop_ready_o  = 1'b0;
    mem_we       = 1'b0;
    div_req      = '0;

    if (cfg_valid_i) begin
      start_d = cfg_data_i;
    end
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_item_i.is_query) begin
            upt_num_d  = elapsed;
            upt_rem_d  = '0;
            upt_step_d = '0;
            state_d    = ST_Q_UPT;
          end else begin
            last_time_d  = pop_item_i.now_ms;
            last_count_d = pop_item_i.count;
            if (span == '0) begin
              rate_d  = '0;
              state_d = ST_TICK_WR;
            end else begin
              div_req.start = 1'b1;
              div_req.num   = scaled;
              div_req.den   = span;
              state_d       = ST_TICK_DIV;
            end
          end
        end
      end
      ST_TICK_DIV: begin
        if (div_rsp.done) begin
          rate_d  = sat_rate;
          state_d = ST_TICK_WR;
        end
      end
      ST_TICK_WR: begin
        // The running sum and count of nonzero samples follow every overwrite.
        mem_we            = 1'b1;
        valid_d[wr_idx_q] = 1'b1;
        sum_d  = sum_q - SUM_W'(old_rate) + SUM_W'(rate_q);
        used_d = used_q - USED_W'(old_rate != '0) + USED_W'(rate_q != '0);
        wr_idx_d = (wr_idx_q == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : wr_idx_q + IDX_W'(1);
        state_d  = ST_IDLE;
      end
      ST_Q_UPT: begin
        upt_num_d  = {upt_num_q[TIME_W-UPT_STEP_BITS-1:0], ud_bits};
        upt_rem_d  = ud_rem;
        upt_step_d = upt_step_q + UPT_STEP_W'(1);
        if (upt_step_q == UPT_STEP_W'(UPT_STEPS - 1)) begin
          upt_d = upt_num_d[UPT_W-1:0];
          if (used_q == '0) begin
            avg_d   = '0;
            state_d = ST_Q_OUT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(sum_q);
            div_req.den   = DEN_W'(used_q);
            state_d       = ST_Q_AVG;
          end
        end
      end
      ST_Q_AVG: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quo[RATE_W-1:0];
          state_d = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_upt_d   = upt_q;
          out_avg_d   = avg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_q      <= '0;
      last_time_q  <= '0;
      last_count_q <= '0;
      wr_idx_q     <= '0;
      valid_q      <= '0;
      sum_q        <= '0;
      used_q       <= '0;
      rate_q       <= '0;
      upt_q        <= '0;
      avg_q        <= '0;
      out_valid_q  <= 1'b0;
      out_upt_q    <= '0;
      out_avg_q    <= '0;
      upt_num_q    <= '0;
      upt_rem_q    <= '0;
      upt_step_q   <= '0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      last_time_q  <= last_time_d;
      last_count_q <= last_count_d;
      wr_idx_q     <= wr_idx_d;
      valid_q      <= valid_d;
      sum_q        <= sum_d;
      used_q       <= used_d;
      rate_q       <= rate_d;
      upt_q        <= upt_d;
      avg_q        <= avg_d;
      out_valid_q  <= out_valid_d;
      out_upt_q    <= out_upt_d;
      out_avg_q    <= out_avg_d;
      upt_num_q    <= upt_num_d;
      upt_rem_q    <= upt_rem_d;
      upt_step_q   <= upt_step_d;
    end
  end

  // Sample store; the slot at the write index is read every cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= rate_q;
    end
    rdata_q <= mem_q[wr_idx_q];
  end

endmodule

`default_nettype wire

>>> src/ops_rate_meter_top.sv
// Operation event counter with tick-sampled rate store and uptime / average-rate queries.
// Operation events are taken one per cycle and never wait for the back end.
// A tick uses the shared 74-step bit-serial divider for its rate unless its span is zero;
// a query uses it for the average unless no sample is nonzero; a two-entry queue holds both.
// A query runs ST_Q_UPT and ST_Q_AVG; ST_Q_OUT registers its result once the output is free.
// Asynchronous active-low reset clears the counters, the sample store valid bits and start_ms.
`default_nettype none

module ops_rate_meter_top import orm_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [TIME_W-1:0]      cfg_data_i,      // [47:0] start_ms
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [47:0] now_ms
  input  wire logic [CMD_W-1:0]       s_axis_tuser_i,  // [1:0] command
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o   // [38:0] uptime_s, [86:39] avg_rate
);

  q_item_t push_item, pop_item;
  logic    push_valid, push_ready, pop_valid, pop_ready;

  orm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_item_o     (push_item),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready)
  );

  orm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  orm_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .pop_item_i      (pop_item),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

>>> tb/rate_meter_checker.sv
// Watches the streams of the operations rate meter, predicts each query answer and compares.
`timescale 1ns / 100ps

module rate_meter_checker import orm_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [TIME_W-1:0]      cfg_data_i,      // [47:0] start_ms
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,       // [47:0] now_ms
  input  logic [CMD_W-1:0]       s_tuser_i,       // [1:0] command
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,       // [38:0] uptime_s, [86:39] avg_rate
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  typedef struct packed {
    logic [UPT_W-1:0]  uptime_s;
    logic [RATE_W-1:0] avg_rate;
  } report_t;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  logic [TIME_W-1:0] start_ms;
  logic [TIME_W-1:0] last_tick_ms;
  logic [CNT_W-1:0]  op_count;
  logic [CNT_W-1:0]  last_tick_ops;
  int unsigned       next_slot;
  logic [RATE_W-1:0] rate_store [SAMPLE_COUNT];
  report_t           expected_reports [$];
  report_t           seen;
  report_t           want;

  // Exact floor(ops * 1000 / span_ms), saturated to the sample width; zero for a zero span.
  function automatic logic [RATE_W-1:0] tick_rate(input logic [CNT_W-1:0] ops,
                                                  input logic [TIME_W-1:0] span_ms);
    logic [79:0] scaled;
    logic [79:0] quo;
    if (span_ms == '0) return '0;
    scaled = {16'd0, ops} * 80'd1000;
    quo    = scaled / {32'd0, span_ms};
    return (quo > {32'd0, RATE_MAX}) ? RATE_MAX : quo[RATE_W-1:0];
  endfunction

  function automatic logic [RATE_W-1:0] mean_rate();
    logic [63:0] sum;
    logic [63:0] used;
    logic [63:0] quo;
    sum  = '0;
    used = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (rate_store[i] != '0) begin
        sum  = sum + {16'd0, rate_store[i]};
        used = used + 64'd1;
      end
    end
    quo = (used == '0) ? '0 : sum / used;
    return quo[RATE_W-1:0];
  endfunction

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    report_t           r;
    case (cmd)
      CMD_OP: begin
        op_count = op_count + 64'd1;
      end
      CMD_TICK: begin
        // Both differences wrap, so time going backwards gives a huge span.
        rate_store[next_slot] = tick_rate(op_count - last_tick_ops, now - last_tick_ms);
        last_tick_ms  = now;
        last_tick_ops = op_count;
        next_slot     = (next_slot + 1) % SAMPLE_COUNT;
      end
      CMD_QUERY: begin
        elapsed    = now - start_ms;
        elapsed    = elapsed / MS_PER_S;
        r.uptime_s = elapsed[UPT_W-1:0];
        r.avg_rate = mean_rate();
        expected_reports.push_back(r);
      end
      default: begin
        // The unused command leaves everything as it is.
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ms      = '0;
      last_tick_ms  = '0;
      op_count      = '0;
      last_tick_ops = '0;
      next_slot     = 0;
      for (int i = 0; i < SAMPLE_COUNT; i++) rate_store[i] = '0;
      expected_reports.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) start_ms = cfg_data_i;
      if (s_tvalid_i && s_tready_i) predict_command(s_tuser_i, s_tdata_i[TIME_W-1:0]);
      if (m_tvalid_i && m_tready_i) begin
        seen.uptime_s = m_tdata_i[UPT_W-1:0];
        seen.avg_rate = m_tdata_i[UPT_W +: RATE_W];
        if (expected_reports.size() == 0) begin
          $error("query answer with no query outstanding: uptime_s %0d avg_rate %0d",
                 seen.uptime_s, seen.avg_rate);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          if (seen.uptime_s != want.uptime_s) begin
            $error("uptime_s mismatch: expected %0d, actual %0d", want.uptime_s, seen.uptime_s);
            fail_count_o++;
          end
          if (seen.avg_rate != want.avg_rate) begin
            $error("avg_rate mismatch: expected %0d, actual %0d", want.avg_rate, seen.avg_rate);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the operations rate meter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import orm_pkg::*;

  localparam int unsigned SAMPLES       = 16;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 200;
  // Up to three ticks may still be queued or in the back end when the last answer arrives.
  localparam int unsigned SETTLE_CYCLES = 500;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned HOLD_AFTER    = 10;
  localparam int unsigned LIMIT_CYCLES  = 2000000;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [TIME_W-1:0]      cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]       s_tuser   = '0;
  logic                   m_tready  = 1'b0;
  wire                    cfg_ready;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [OUT_TDATA_W-1:0]  m_tdata;
  int unsigned            fail_count;
  int unsigned            pending;

  logic [TIME_W-1:0]      clock_ms   = '0;
  int unsigned            burst_left = 1;

  ops_rate_meter_top #(.SAMPLE_COUNT(SAMPLES)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  rate_meter_checker #(.SAMPLE_COUNT(SAMPLES)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [TIME_W-1:0] rand48();
    logic [TIME_W-1:0] v;
    v[47:32] = 16'($urandom_range(0, 16'hFFFF));
    v[31:0]  = $urandom();
    return v;
  endfunction

  // Offers one item and returns at the edge of its transfer; ends bursts with a random gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= now;
    do @(posedge clk_i); while (!s_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_start(input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering items and waits until every answer is in and pending ticks are done.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      send_item(CMD_OP, rand48());
    end else if (pick < 97) begin
      // Time mostly moves forward in small steps, with stalls, jumps and steps back.
      step = $urandom_range(0, 99);
      if (step < 70)      clock_ms = clock_ms + $urandom_range(1, 2000);
      else if (step < 88) clock_ms = clock_ms - $urandom_range(1, 5000);
      else if (step < 95) clock_ms = rand48();
      else if (step < 98) clock_ms = clock_ms + $urandom_range(0, 100000);
      send_item((pick < 85) ? CMD_TICK : CMD_QUERY, clock_ms);
    end else begin
      send_item(CMD_UNUSED, rand48());
    end
  endtask

  // Receiver: a changing stall pattern, and one long hold-off once a few answers have come.
  initial begin
    int unsigned cycle;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned answers;
    bit          held;
    cycle     = 0;
    mode      = 0;
    hold_left = 0;
    answers   = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) answers++;
      if (!held && answers >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (cycle % 200 == 0) mode = $urandom_range(0, 3);
      cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((cycle / 3) % 2 == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $error("run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: uptime wrapping below start, zero intervals, time stepping back,
    // the unused command, and the extremes of the timestamp.
    write_start(48'd5000);
    send_item(CMD_QUERY, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_OP, TIME_MAX);
    send_item(CMD_OP, '0);
    send_item(CMD_OP, rand48());
    send_item(CMD_TICK, 48'd1);
    send_item(CMD_QUERY, TIME_MAX);
    send_item(CMD_UNUSED, TIME_MAX);
    send_item(CMD_UNUSED, '0);
    send_item(CMD_OP, rand48());
    send_item(CMD_OP, rand48());
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_QUERY, 48'd5000);
    repeat (4) send_item(CMD_OP, rand48());
    send_item(CMD_TICK, 48'd1000);
    send_item(CMD_TICK, TIME_MAX);
    send_item(CMD_QUERY, 48'd5999);
    send_item(CMD_QUERY, 48'd6000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       write_start('0);
        1:       write_start(TIME_MAX);
        2:       write_start(clock_ms);
        3:       write_start(clock_ms - $urandom_range(0, 100000));
        default: write_start(rand48());
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    if (pending != 0) $error("%0d query answers never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> ops_rate_meter_top.f
src/orm_pkg.sv
src/orm_front.sv
src/orm_queue.sv
src/orm_div.sv
src/orm_back.sv
src/ops_rate_meter_top.sv
tb/rate_meter_checker.sv
tb/testbench.sv
